### src/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mui_pkg.sv
// Package for the modular inverse unit: microcode types, status struct and ROM.
// No dependencies; used by mui_sequencer, mui_datapath and the top level.
package mui_pkg;

    localparam int WORD_WIDTH_DEFAULT = 32;
    localparam int FIELD_W = 32;
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'hFFFF_FFFB;

    localparam int UPC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETUP,
        OP_ALIGN,
        OP_SUB,
        OP_SWAP,
        OP_FIX,
        OP_RES_OK,
        OP_RES_FAIL
    } op_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_M_ZERO,
        COND_CAN_SHIFT,
        COND_K_NZ,
        COND_R1_NZ,
        COND_R0_NE1,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic                accept;
        op_t                 op;
        cond_t               cond;
        logic [UPC_W-1:0]    target;
    } ctrl_word_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic m_zero;
        logic can_shift;
        logic k_nz;
        logic r1_nz;
        logic r0_ne1;
        logic out_busy;
    } stat_t;

    // Program addresses
    localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_CHKM   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_SETUP  = 4'd2;
    localparam logic [UPC_W-1:0] UPC_ALIGN  = 4'd3;
    localparam logic [UPC_W-1:0] UPC_SUB    = 4'd4;
    localparam logic [UPC_W-1:0] UPC_SWAP   = 4'd5;
    localparam logic [UPC_W-1:0] UPC_LOOP   = 4'd6;
    localparam logic [UPC_W-1:0] UPC_GCD    = 4'd7;
    localparam logic [UPC_W-1:0] UPC_FIX    = 4'd8;
    localparam logic [UPC_W-1:0] UPC_OK     = 4'd9;
    localparam logic [UPC_W-1:0] UPC_FAIL   = 4'd10;

    // Microcode ROM. The first pass through SETUP..SWAP reduces the operand
    // modulo the modulus; later passes are Euclid steps.
    function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '{accept: 1'b0, op: OP_NOP, cond: COND_ALWAYS, target: UPC_IDLE};
        case (addr)
            UPC_IDLE:  w = '{1'b1, OP_LOAD,     COND_NO_INPUT,  UPC_IDLE};
            UPC_CHKM:  w = '{1'b0, OP_NOP,      COND_M_ZERO,    UPC_FAIL};
            UPC_SETUP: w = '{1'b0, OP_SETUP,    COND_NONE,      UPC_IDLE};
            UPC_ALIGN: w = '{1'b0, OP_ALIGN,    COND_CAN_SHIFT, UPC_ALIGN};
            UPC_SUB:   w = '{1'b0, OP_SUB,      COND_K_NZ,      UPC_SUB};
            UPC_SWAP:  w = '{1'b0, OP_SWAP,     COND_NONE,      UPC_IDLE};
            UPC_LOOP:  w = '{1'b0, OP_NOP,      COND_R1_NZ,     UPC_SETUP};
            UPC_GCD:   w = '{1'b0, OP_NOP,      COND_R0_NE1,    UPC_FAIL};
            UPC_FIX:   w = '{1'b0, OP_FIX,      COND_NONE,      UPC_IDLE};
            UPC_OK:    w = '{1'b0, OP_RES_OK,   COND_OUT_FREE,  UPC_IDLE};
            UPC_FAIL:  w = '{1'b0, OP_RES_FAIL, COND_OUT_FREE,  UPC_IDLE};
            default:   w = '{1'b0, OP_NOP,      COND_ALWAYS,    UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/mui_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on mui_pkg.
module mui_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mui_pkg::stat_t      stat,
    output mui_pkg::ctrl_word_t ctrl
);

    logic [mui_pkg::UPC_W-1:0] upc_reg;
    logic [mui_pkg::UPC_W-1:0] upc_next;

    assign ctrl = mui_pkg::ucode(upc_reg);

    always_comb
    begin
        upc_next = upc_reg + mui_pkg::UPC_W'(1);
        case (ctrl.cond)
            mui_pkg::COND_NONE:      upc_next = upc_reg + mui_pkg::UPC_W'(1);
            mui_pkg::COND_ALWAYS:    upc_next = ctrl.target;
            mui_pkg::COND_NO_INPUT:  if (!in_valid) upc_next = ctrl.target;
            mui_pkg::COND_M_ZERO:    if (stat.m_zero) upc_next = ctrl.target;
            mui_pkg::COND_CAN_SHIFT: if (stat.can_shift) upc_next = ctrl.target;
            mui_pkg::COND_K_NZ:      if (stat.k_nz) upc_next = ctrl.target;
            mui_pkg::COND_R1_NZ:     if (stat.r1_nz) upc_next = ctrl.target;
            mui_pkg::COND_R0_NE1:    if (stat.r0_ne1) upc_next = ctrl.target;
            // hold until the output register can take the word
            mui_pkg::COND_OUT_FREE:  upc_next = stat.out_busy ? upc_reg : ctrl.target;
            default:                 upc_next = mui_pkg::UPC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= mui_pkg::UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

### src/mui_datapath.sv
// Datapath: remainder/coefficient registers, shift-subtract divider, output register.
// Depends on mui_pkg; driven by the op field of the microcode word.
module mui_datapath #(
    parameter int WORD_WIDTH = mui_pkg::WORD_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mui_pkg::op_t                op,
    input  logic                        in_valid,
    input  logic [mui_pkg::FIELD_W-1:0] operand,
    input  logic [mui_pkg::FIELD_W-1:0] modulus,
    input  logic                        out_ready,
    output logic [mui_pkg::FIELD_W-1:0] inverse,
    output logic                        no_inverse,
    output logic                        out_valid,
    output mui_pkg::stat_t              stat
);

    localparam int KW = $clog2(WORD_WIDTH);

    logic [WORD_WIDTH-1:0] a_w;
    logic [WORD_WIDTH-1:0] m_w;

    logic [WORD_WIDTH-1:0] r0_reg, r0_next;
    logic [WORD_WIDTH-1:0] r1_reg, r1_next;
    logic [WORD_WIDTH-1:0] u0_reg, u0_next;
    logic [WORD_WIDTH-1:0] u1_reg, u1_next;
    logic [WORD_WIDTH-1:0] d_reg, d_next;
    logic [WORD_WIDTH-1:0] ud_reg, ud_next;
    logic [KW-1:0]         k_reg, k_next;
    logic                  neg_reg, neg_next;

    logic [mui_pkg::FIELD_W-1:0] inv_reg, inv_next;
    logic                        noinv_reg, noinv_next;
    logic                        outv_reg, outv_next;

    logic                  can_shift;
    logic                  sub_ok;
    logic                  out_busy;
    logic [WORD_WIDTH-1:0] res_w;

    assign a_w = WORD_WIDTH'(operand);
    assign m_w = WORD_WIDTH'(modulus);

    // divisor may double only while it still fits under the remainder
    assign can_shift = !d_reg[WORD_WIDTH-1] && ({d_reg[WORD_WIDTH-2:0], 1'b0} <= r0_reg);
    assign sub_ok    = d_reg <= r0_reg;
    assign out_busy  = outv_reg && !out_ready;
    assign res_w     = (neg_reg && (u0_reg != '0)) ? (m_w - u0_reg) : u0_reg;

    assign stat.m_zero    = m_w == '0;
    assign stat.can_shift = can_shift;
    assign stat.k_nz      = k_reg != '0;
    assign stat.r1_nz     = r1_reg != '0;
    assign stat.r0_ne1    = r0_reg != WORD_WIDTH'(1);
    assign stat.out_busy  = out_busy;

    assign inverse    = inv_reg;
    assign no_inverse = noinv_reg;
    assign out_valid  = outv_reg;

    always_comb
    begin
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        u0_next    = u0_reg;
        u1_next    = u1_reg;
        d_next     = d_reg;
        ud_next    = ud_reg;
        k_next     = k_reg;
        neg_next   = neg_reg;
        inv_next   = inv_reg;
        noinv_next = noinv_reg;
        outv_next  = outv_reg && !out_ready;
        case (op)
            mui_pkg::OP_NOP:
            begin
            end
            mui_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    // first pass computes operand mod modulus in r0
                    r0_next  = a_w;
                    r1_next  = m_w;
                    u0_next  = WORD_WIDTH'(1);
                    u1_next  = '0;
                    neg_next = 1'b0;
                end
            end
            mui_pkg::OP_SETUP:
            begin
                d_next  = r1_reg;
                ud_next = u1_reg;
                k_next  = '0;
            end
            mui_pkg::OP_ALIGN:
            begin
                if (can_shift)
                begin
                    d_next  = {d_reg[WORD_WIDTH-2:0], 1'b0};
                    ud_next = {ud_reg[WORD_WIDTH-2:0], 1'b0};
                    k_next  = k_reg + KW'(1);
                end
            end
            mui_pkg::OP_SUB:
            begin
                // one quotient bit; coefficient accumulates q*u1 on top of u0
                if (sub_ok)
                begin
                    r0_next = r0_reg - d_reg;
                    u0_next = u0_reg + ud_reg;
                end
                d_next  = d_reg >> 1;
                ud_next = ud_reg >> 1;
                k_next  = k_reg - KW'(1);
            end
            mui_pkg::OP_SWAP:
            begin
                r0_next  = r1_reg;
                r1_next  = r0_reg;
                u0_next  = u1_reg;
                u1_next  = u0_reg;
                neg_next = !neg_reg;
            end
            mui_pkg::OP_FIX:
            begin
                if (u0_reg >= m_w)
                begin
                    u0_next = u0_reg - m_w;
                end
            end
            mui_pkg::OP_RES_OK:
            begin
                if (!out_busy)
                begin
                    inv_next   = mui_pkg::FIELD_W'(res_w);
                    noinv_next = 1'b0;
                    outv_next  = 1'b1;
                end
            end
            mui_pkg::OP_RES_FAIL:
            begin
                if (!out_busy)
                begin
                    inv_next   = '0;
                    noinv_next = 1'b1;
                    outv_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        u0_reg    <= u0_next;
        u1_reg    <= u1_next;
        d_reg     <= d_next;
        ud_reg    <= ud_next;
        k_reg     <= k_next;
        neg_reg   <= neg_next;
        inv_reg   <= inv_next;
        noinv_reg <= noinv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else
        begin
            outv_reg <= outv_next;
        end
    end

endmodule

### src/modular_inverse_unit_core.sv
// Modular inverse unit, top level: modulus register, sequencer and datapath.
// Depends on mui_pkg, mui_sequencer, mui_datapath and assert_macros.svh.
//
// Input channel (in_valid/in_ready, operand) takes one word; the output
// channel (out_valid/out_ready, inverse, no_inverse) returns one word for it.
// The modulus is written through modulus_wr_en/modulus_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// inverse is operand^-1 mod modulus; when gcd(operand, modulus) != 1,
// no_inverse is set and inverse is zero.
// Each Euclid step is one pass of the one-bit-per-cycle shift/subtract divider,
// and the initial reduction is one such pass, with the modulus check before
// and the closing steps after. One item is in work at a time, and in_ready is
// high only at the program's idle step.
// Reset clears the step counter and the output valid, and sets the modulus
// to 0xFFFFFFFB. A finished word waits in the output register; the next
// input word is accepted meanwhile, and its result waits at the final step
// until the receiver takes the earlier one.
`include "assert_macros.svh"

module modular_inverse_unit_core #(
    parameter int WORD_WIDTH = mui_pkg::WORD_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mui_pkg::FIELD_W-1:0] operand,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mui_pkg::FIELD_W-1:0] inverse,
    output logic                        no_inverse,
    input  logic                        modulus_wr_en,
    input  logic [mui_pkg::FIELD_W-1:0] modulus_wr_data
);

    logic [mui_pkg::FIELD_W-1:0] modulus_reg;
    logic [mui_pkg::FIELD_W-1:0] modulus_next;
    mui_pkg::ctrl_word_t         ctrl;
    mui_pkg::stat_t              stat;

    assign modulus_next = modulus_wr_en ? modulus_wr_data : modulus_reg;
    assign in_ready     = ctrl.accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mui_pkg::MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    mui_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mui_datapath #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ctrl.op),
        .in_valid   (in_valid),
        .operand    (operand),
        .modulus    (modulus_reg),
        .out_ready  (out_ready),
        .inverse    (inverse),
        .no_inverse (no_inverse),
        .out_valid  (out_valid),
        .stat       (stat)
    );

    // an accepted word leaves the program busy in the cycle after it is taken
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready,
        "input taken twice in a row")
    // no inverse always reads as zero
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && no_inverse, inverse == '0,
        "no_inverse with nonzero inverse")
    // a new result is written only from a result step, never from idle
    `ASSERT_IMPL(a_result_src, clk, rst_n, $rose(out_valid), $past(!in_ready),
        "result written from idle step")

endmodule

### sim/tb_modular_inverse_unit_core.sv
// Testbench for modular_inverse_unit_core: checks each returned inverse word
// against an in-bench extended Euclid predictor. Depends on mui_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic [mui_pkg::FIELD_W-1:0] inverse;
    logic                        no_inverse;
} inv_word_t;

class inverse_checker;
    logic [mui_pkg::FIELD_W-1:0] modulus;
    inv_word_t                   inverse_q[$];
    int                          errors;

    function new();
        modulus = mui_pkg::MODULUS_RESET;
        errors  = 0;
    endfunction

    function void set_modulus(logic [mui_pkg::FIELD_W-1:0] m);
        modulus = m;
    endfunction

    function int pending();
        return inverse_q.size();
    endfunction

    // Euclid with remainders and the operand coefficient kept as magnitude plus
    // a sign that flips every step.
    function inv_word_t predict_inverse(logic [mui_pkg::FIELD_W-1:0] a);
        logic [63:0] m, rem_a, rem_b, rem_n, coef_a, coef_b, coef_n, quot;
        bit          neg_a, neg_b;
        int          n;
        inv_word_t   res;
        res.inverse    = '0;
        res.no_inverse = 1'b1;
        m = 64'(modulus);
        if (m == 0)
            return res;
        rem_a  = m;
        rem_b  = 64'(a) % m;
        coef_a = 0;
        coef_b = 1;
        neg_a  = 1'b0;
        neg_b  = 1'b0;
        for (n = 0; n < 2 * mui_pkg::FIELD_W + 4 && rem_b != 0; n++)
        begin
            quot   = rem_a / rem_b;
            rem_n  = rem_a - quot * rem_b;
            coef_n = coef_a + quot * coef_b;
            rem_a  = rem_b;
            rem_b  = rem_n;
            coef_a = coef_b;
            neg_a  = neg_b;
            coef_b = coef_n;
            neg_b  = !neg_b;
        end
        if (rem_b != 0 || rem_a != 1)
            return res;
        coef_a = coef_a % m;
        res.no_inverse = 1'b0;
        res.inverse    = (neg_a && coef_a != 0) ? 32'(m - coef_a) : 32'(coef_a);
        return res;
    endfunction

    function void note_operand(logic [mui_pkg::FIELD_W-1:0] a);
        inverse_q.push_back(predict_inverse(a));
    endfunction

    function void check_inverse(logic [mui_pkg::FIELD_W-1:0] inv, logic flag);
        inv_word_t exp_w;
        if (inverse_q.size() == 0)
        begin
            $error("unexpected word: inverse %h no_inverse %b", inv, flag);
            errors++;
            return;
        end
        exp_w = inverse_q.pop_front();
        if (inv !== exp_w.inverse)
        begin
            $error("inverse: expected %h, got %h", exp_w.inverse, inv);
            errors++;
        end
        if (flag !== exp_w.no_inverse)
        begin
            $error("no_inverse: expected %b, got %b", exp_w.no_inverse, flag);
            errors++;
        end
    endfunction
endclass

module tb_modular_inverse_unit_core;
    localparam int W          = mui_pkg::FIELD_W;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 1500;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 63;
    localparam logic [W-1:0] FIB_47 = 32'd2971215073;
    localparam logic [W-1:0] FIB_46 = 32'd1836311903;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] operand;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] inverse;
    logic         no_inverse;
    logic         modulus_wr_en;
    logic [W-1:0] modulus_wr_data;

    inverse_checker chk = new();

    bit src_eager;
    bit snk_eager;
    bit hold_req;
    int idle_cycles = 0;

    modular_inverse_unit_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operand         (operand),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .inverse         (inverse),
        .no_inverse      (no_inverse),
        .modulus_wr_en   (modulus_wr_en),
        .modulus_wr_data (modulus_wr_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [W-1:0] pick_operand(logic [W-1:0] m);
        logic [63:0] wide;
        int          d;
        case ($urandom_range(0, 9))
            4:       return W'($urandom_range(0, 15));
            5:       return m - W'($urandom_range(0, 3));
            6:       return m + W'($urandom_range(0, 7));
            7:
            begin
                // shares a small factor with many moduli
                d = $urandom_range(2, 17);
                return W'(d) * W'($urandom_range(0, 32'hFFFF_FFFF / d));
            end
            8:
            begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return W'(1) << $urandom_range(0, W - 1);
                endcase
            end
            9:
            begin
                wide = 64'(m) * 64'($urandom_range(0, 3)) + 64'd1;
                return wide[W-1:0];
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [W-1:0] pick_modulus(int p);
        case (p)
            0:       return mui_pkg::MODULUS_RESET;
            1:       return '1;
            2:       return $urandom;
            3:       return W'($urandom_range(2, 255));
            4:       return W'(1) << $urandom_range(1, W - 1);
            5:       return W'($urandom_range(256, 65535));
            6:       return FIB_47;
            7:       return W'(1);
            8:       return $urandom | 32'h8000_0000;
            default: return W'($urandom_range(2, 20));
        endcase
    endfunction

    task automatic send_word(input logic [W-1:0] v);
        int gap;
        gap = pick_gap(src_eager);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        operand  <= v;
        do @(posedge clk); while (!in_ready);
        chk.note_operand(v);
    endtask

    // drop valid and wait until every expected word has come back
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_modulus(input logic [W-1:0] m);
        drain();
        repeat (4) @(negedge clk);
        modulus_wr_en   <= 1'b1;
        modulus_wr_data <= m;
        @(negedge clk);
        modulus_wr_en   <= 1'b0;
        chk.set_modulus(m);
    endtask

    // result side
    initial
    begin : result_sink
        int  stall;
        bit  hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                stall     = LONG_HOLD;
                hold_done = 1'b1;
            end
            else
                stall = pick_gap(snk_eager);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            chk.check_inverse(inverse, no_inverse);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles < IDLE_LIMIT)
            idle_cycles <= idle_cycles + 1;
        else
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [W-1:0] m;
        int           p;
        int           k;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operand         = '0;
        modulus_wr_en   = 1'b0;
        modulus_wr_data = '0;
        src_eager       = 1'b0;
        snk_eager       = 1'b0;
        hold_req        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset modulus: zero, one, values around the modulus, top bit
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'h0000_0002);
        send_word(32'h0000_0003);
        send_word(32'hFFFF_FFFA);
        send_word(32'hFFFF_FFFB);
        send_word(32'hFFFF_FFFC);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        // modulus one: inverse always zero, flag clear
        load_modulus(32'h0000_0001);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        // modulus zero: never invertible
        load_modulus(32'h0000_0000);
        send_word(32'h0000_0005);
        send_word(32'h0000_0000);
        // all-ones modulus is composite
        load_modulus(32'hFFFF_FFFF);
        send_word(32'h0000_0003);
        send_word(32'h0000_0002);
        send_word(32'hFFFF_FFFE);
        send_word(32'h5555_5555);
        // consecutive Fibonacci numbers give the longest Euclid chain
        load_modulus(FIB_47);
        send_word(FIB_46);
        send_word(FIB_47 - 1);
        load_modulus(32'h0000_0002);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);

        for (p = 0; p < PHASES; p++)
        begin
            m = pick_modulus(p);
            load_modulus(m);
            src_eager = ($urandom_range(0, 3) == 0);
            snk_eager = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_LEN; k++)
            begin
                // receiver stops for a long while; the block backs up
                if (p == 2 && k == 10)
                    hold_req = 1'b1;
                send_word(pick_operand(m));
            end
        end

        drain();
        repeat (500) @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/mui_pkg.sv
src/mui_sequencer.sv
src/mui_datapath.sv
src/modular_inverse_unit_core.sv
sim/tb_modular_inverse_unit_core.sv
